/* rtl/core/cdn_pkg.sv */
package cdn_pkg;

    localparam int BASE_YEAR = 1901;
    localparam int YEAR_SPAN = 256;
    localparam logic [16:0] LAST_NUM = 17'd93503;
    localparam logic [18:0] RECIP_1461 = 19'd367469;
    localparam int RECIP_SHIFT = 29;

    typedef enum logic [1:0] {
        OP_TO_NUM  = 2'd0,
        OP_TO_DATE = 2'd1,
        OP_DIFF    = 2'd2,
        OP_BAD     = 2'd3
    } t_op;

    typedef struct packed {
        logic        ok;
        logic [16:0] serial;
    } t_ser;

    typedef struct packed {
        logic        ok;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
    } t_dmy;

    // leap test on year offset from base year, valid inside the span
    function automatic logic leap_off(input logic [7:0] yo);
        return (yo[1:0] == 2'd3) && (yo != 8'd199);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] cum_days(input logic [3:0] m, input logic leap);
        logic [8:0] c;
        case (m)
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59;
            4'd4:    c = 9'd90;
            4'd5:    c = 9'd120;
            4'd6:    c = 9'd151;
            4'd7:    c = 9'd181;
            4'd8:    c = 9'd212;
            4'd9:    c = 9'd243;
            4'd10:   c = 9'd273;
            4'd11:   c = 9'd304;
            4'd12:   c = 9'd334;
            default: c = 9'd0;
        endcase
        return c + 9'((leap && (m > 4'd2)) ? 1 : 0);
    endfunction

    // days in all years before offset yo
    function automatic logic [16:0] days_before(input logic [8:0] yo);
        return 17'(17'(yo) * 17'd365) + 17'(yo[8:2]) - 17'((yo >= 9'd200) ? 1 : 0);
    endfunction

endpackage

/* rtl/core/cdn_in_if.sv */
interface cdn_in_if;
    import cdn_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [4:0]  day_a;
    logic [3:0]  month_a;
    logic [11:0] year_a;
    logic [4:0]  day_b;
    logic [3:0]  month_b;
    logic [11:0] year_b;
    logic [16:0] day_number_in;

    modport source (output valid, operation, day_a, month_a, year_a, day_b, month_b,
                    year_b, day_number_in, input ready);
    modport sink (input valid, operation, day_a, month_a, year_a, day_b, month_b,
                  year_b, day_number_in, output ready);
endinterface

/* rtl/core/cdn_out_if.sv */
interface cdn_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  day_out;
    logic [3:0]  month_out;
    logic [11:0] year_out;
    logic [16:0] day_number_out;
    logic        status;

    modport source (output valid, day_out, month_out, year_out, day_number_out, status,
                    input ready);
    modport sink (input valid, day_out, month_out, year_out, day_number_out, status,
                  output ready);
endinterface

/* rtl/core/cdn_date_to_num.sv */
module cdn_date_to_num
    import cdn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [4:0]  i_day,
    input  logic [3:0]  i_month,
    input  logic [11:0] i_year,
    output t_ser        o_ser
);
    logic [11:0] w_yo;
    logic        w_leap;
    logic        w_ok;
    logic        r_ok;
    logic [7:0]  r_yo;
    logic [8:0]  r_doy;
    t_ser        r_ser;

    always_comb begin
        w_yo   = i_year - 12'(BASE_YEAR);
        w_leap = leap_off(w_yo[7:0]);
        w_ok   = (i_year >= 12'(BASE_YEAR)) && (w_yo < 12'(YEAR_SPAN))
                 && (i_month >= 4'd1) && (i_month <= 4'd12)
                 && (i_day >= 5'd1) && (i_day <= month_len(i_month, w_leap));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ok         <= w_ok;
            r_yo         <= w_yo[7:0];
            r_doy        <= cum_days(i_month, w_leap) + 9'(i_day);
            r_ser.ok     <= r_ok;
            r_ser.serial <= days_before({1'b0, r_yo}) + 17'(r_doy);
        end
    end

    assign o_ser = r_ser;
endmodule

/* rtl/core/cdn_num_to_date.sv */
module cdn_num_to_date
    import cdn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [16:0] i_num,
    output t_dmy        o_dmy
);
    logic        r_ok_a, r_ok_b, r_ok_c, r_ok_d;
    logic [16:0] r_t_a, r_t_b, r_t_c, r_t_d;
    logic [18:0] r_x_a;
    logic [7:0]  r_q_b;
    logic [16:0] r_dm_c, r_d0_c, r_d1_c;
    logic [7:0]  r_q_c;
    logic [7:0]  r_yo_d;
    logic [8:0]  r_r_d;
    logic [37:0] w_prod;
    logic [8:0]  w_q9;
    logic [7:0]  n_yo;
    logic [16:0] n_base;
    logic        w_leap;
    logic [3:0]  n_month;
    logic [8:0]  w_cum;
    t_dmy        r_dmy;

    assign w_prod = 38'(r_x_a) * 38'(RECIP_1461);
    assign w_q9   = {1'b0, r_q_b};

    always_comb begin
        if (r_d0_c > r_t_c) begin
            n_yo   = r_q_c - 8'd1;
            n_base = r_dm_c;
        end else if (r_d1_c <= r_t_c) begin
            n_yo   = r_q_c + 8'd1;
            n_base = r_d1_c;
        end else begin
            n_yo   = r_q_c;
            n_base = r_d0_c;
        end
    end

    always_comb begin
        w_leap  = leap_off(r_yo_d);
        n_month = 4'd1;
        for (int k = 2; k <= 12; k++) begin
            if (cum_days(4'(k), w_leap) <= r_r_d) begin
                n_month = 4'(k);
            end
        end
        w_cum = cum_days(n_month, w_leap);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ok_a <= (i_num != 17'd0) && (i_num <= LAST_NUM);
            r_t_a  <= i_num - 17'd1;
            r_x_a  <= {i_num - 17'd1, 2'b11};
            r_ok_b <= r_ok_a;
            r_t_b  <= r_t_a;
            r_q_b  <= w_prod[RECIP_SHIFT+7:RECIP_SHIFT];
            r_ok_c <= r_ok_b;
            r_t_c  <= r_t_b;
            r_q_c  <= r_q_b;
            r_dm_c <= (r_q_b == 8'd0) ? 17'd0 : days_before(w_q9 - 9'd1);
            r_d0_c <= days_before(w_q9);
            r_d1_c <= days_before(w_q9 + 9'd1);
            r_ok_d <= r_ok_c;
            r_t_d  <= r_t_c;
            r_yo_d <= n_yo;
            r_r_d  <= 9'(r_t_c - n_base);
            r_dmy.ok    <= r_ok_d && (r_t_d <= 17'(LAST_NUM));
            r_dmy.month <= n_month;
            r_dmy.day   <= 5'(r_r_d - w_cum + 9'd1);
            r_dmy.year  <= 12'(BASE_YEAR) + 12'(r_yo_d);
        end
    end

    assign o_dmy = r_dmy;
endmodule

/* rtl/core/calendar_day_number_converter.sv */
// Throughput: one transfer per cycle; all stages hold while the result waits.
// Year found by reciprocal multiply of the day number with a one-year fix-up.
// Reset: synchronous, active low; clears the stage valid bits only.
module calendar_day_number_converter
    import cdn_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    cdn_in_if.sink   i_req,
    cdn_out_if.source o_rsp
);
    logic        w_en;
    logic [4:0]  r_v;
    logic [1:0]  r_op [5];
    t_ser        w_ser_a, w_ser_b;
    t_dmy        w_dmy;
    logic [16:0] r_num3, r_num4, r_num5;
    logic        r_dok3, r_dok4, r_dok5;
    logic        r_valid;
    logic [4:0]  r_day;
    logic [3:0]  r_month;
    logic [11:0] r_year;
    logic [16:0] r_num;
    logic        r_status;

    assign w_en        = !r_valid || o_rsp.ready;
    assign i_req.ready = w_en;

    cdn_date_to_num u_dta (
        .i_clk(i_clk), .i_en(w_en), .i_day(i_req.day_a), .i_month(i_req.month_a),
        .i_year(i_req.year_a), .o_ser(w_ser_a)
    );

    cdn_date_to_num u_dtb (
        .i_clk(i_clk), .i_en(w_en), .i_day(i_req.day_b), .i_month(i_req.month_b),
        .i_year(i_req.year_b), .o_ser(w_ser_b)
    );

    cdn_num_to_date u_ntd (
        .i_clk(i_clk), .i_en(w_en), .i_num(i_req.day_number_in), .o_dmy(w_dmy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_v     <= {r_v[3:0], i_req.valid};
            r_valid <= r_v[4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_op[0] <= i_req.operation;
            for (int k = 1; k < 5; k++) begin
                r_op[k] <= r_op[k-1];
            end
            if (r_op[1] == OP_DIFF) begin
                r_num3 <= (w_ser_a.serial > w_ser_b.serial) ?
                          (w_ser_a.serial - w_ser_b.serial) :
                          (w_ser_b.serial - w_ser_a.serial);
                r_dok3 <= w_ser_a.ok && w_ser_b.ok;
            end else begin
                r_num3 <= w_ser_a.serial;
                r_dok3 <= w_ser_a.ok;
            end
            r_num4 <= r_num3;
            r_dok4 <= r_dok3;
            r_num5 <= r_num4;
            r_dok5 <= r_dok4;

            r_day    <= '0;
            r_month  <= '0;
            r_year   <= '0;
            r_num    <= '0;
            r_status <= 1'b1;
            case (t_op'(r_op[4]))
                OP_TO_NUM, OP_DIFF: begin
                    if (r_dok5) begin
                        r_num    <= r_num5;
                        r_status <= 1'b0;
                    end
                end
                OP_TO_DATE: begin
                    if (w_dmy.ok) begin
                        r_day    <= w_dmy.day;
                        r_month  <= w_dmy.month;
                        r_year   <= w_dmy.year;
                        r_status <= 1'b0;
                    end
                end
                default: r_status <= 1'b1;
            endcase
        end
    end

    assign o_rsp.valid          = r_valid;
    assign o_rsp.day_out        = r_day;
    assign o_rsp.month_out      = r_month;
    assign o_rsp.year_out       = r_year;
    assign o_rsp.day_number_out = r_num;
    assign o_rsp.status         = r_status;
endmodule

/* rtl/core/cdn_checker.sv */
module cdn_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [4:0]  i_day,
    input logic [3:0]  i_month,
    input logic [11:0] i_year,
    input logic [16:0] i_num,
    input logic        i_status
);
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_num) && $stable(i_day))
        else $error("stalled result changed");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status |-> i_day == 5'd0 && i_month == 4'd0
            && i_year == 12'd0 && i_num == 17'd0)
        else $error("error result carries data");

    a_date_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_status && i_month != 4'd0 |-> i_num == 17'd0
            && i_month <= 4'd12 && i_day != 5'd0 && i_year >= 12'd1901)
        else $error("bad date result");
endmodule

bind calendar_day_number_converter cdn_checker u_cdn_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_out_valid(o_rsp.valid), .i_out_ready(o_rsp.ready),
    .i_day(o_rsp.day_out), .i_month(o_rsp.month_out), .i_year(o_rsp.year_out),
    .i_num(o_rsp.day_number_out), .i_status(o_rsp.status)
);

/* bench/calendar_day_number_converter_test.sv */
`timescale 1ns / 1ps

module calendar_day_number_converter_test;
    import cdn_pkg::*;

    typedef struct {
        logic [1:0]  op;
        logic [4:0]  da;
        logic [3:0]  ma;
        logic [11:0] ya;
        logic [4:0]  db;
        logic [3:0]  mb;
        logic [11:0] yb;
        logic [16:0] dn;
    } t_req;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
        logic [16:0] num;
        logic        err;
    } t_res;

    typedef struct {
        t_req req;
        bit   fixed;
        t_res res;
    } t_row;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1090;
    localparam int LAST_YEAR = BASE_YEAR + YEAR_SPAN - 1;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cdn_in_if  req_ch ();
    cdn_out_if rsp_ch ();

    calendar_day_number_converter DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    always #1 i_clk = ~i_clk;

    t_res expected_q[$];
    int   n_errors = 0;
    int   n_checked = 0;
    int   n_sent = 0;
    int   n_bad = 0;
    int   idle_pct = 12;
    bit   hold_rsp = 1'b0;
    int   quiet_cycles = 0;

    function automatic bit leap_year(int y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int days_in_month(int m, int y);
        if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
        if (m == 2) return leap_year(y) ? 29 : 28;
        return 31;
    endfunction

    function automatic bit valid_date(int d, int m, int y);
        if (y < BASE_YEAR || y > LAST_YEAR) return 0;
        if (m < 1 || m > 12) return 0;
        return d >= 1 && d <= days_in_month(m, y);
    endfunction

    function automatic int serial_of(int d, int m, int y);
        int acc;
        acc = 0;
        for (int i = BASE_YEAR; i < y; i++) acc += leap_year(i) ? 366 : 365;
        for (int i = 1; i < m; i++) acc += days_in_month(i, y);
        return acc + d;
    endfunction

    function automatic t_res convert(t_req r);
        t_res o;
        int   acc, y, m, s1, s2, last;
        o = '{default: '0};
        last = serial_of(31, 12, LAST_YEAR);
        case (t_op'(r.op))
            OP_TO_NUM: begin
                if (valid_date(r.da, r.ma, r.ya)) o.num = 17'(serial_of(r.da, r.ma, r.ya));
                else o.err = 1'b1;
            end
            OP_TO_DATE: begin
                if (r.dn == 0 || int'(r.dn) > last) begin
                    o.err = 1'b1;
                end else begin
                    acc = 0;
                    y = BASE_YEAR;
                    m = 1;
                    while (acc + (leap_year(y) ? 366 : 365) < int'(r.dn)) begin
                        acc += leap_year(y) ? 366 : 365;
                        y++;
                    end
                    while (m < 12 && acc + days_in_month(m, y) < int'(r.dn)) begin
                        acc += days_in_month(m, y);
                        m++;
                    end
                    o.day = 5'(int'(r.dn) - acc);
                    o.month = 4'(m);
                    o.year = 12'(y);
                end
            end
            OP_DIFF: begin
                if (valid_date(r.da, r.ma, r.ya) && valid_date(r.db, r.mb, r.yb)) begin
                    s1 = serial_of(r.da, r.ma, r.ya);
                    s2 = serial_of(r.db, r.mb, r.yb);
                    o.num = 17'(s1 > s2 ? s1 - s2 : s2 - s1);
                end else begin
                    o.err = 1'b1;
                end
            end
            default: o.err = 1'b1;
        endcase
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        n_errors++;
        $display("MISMATCH result %0d %s: got %0d expected %0d", n_checked, what, got, want);
    endtask

    function automatic t_req blank_req(logic [1:0] op);
        t_req r;
        r = '{op: op, da: 5'd1, ma: 4'd1, ya: 12'd1901, db: 5'd1, mb: 4'd1,
              yb: 12'd1901, dn: 17'd1};
        return r;
    endfunction

    function automatic t_req random_date_req();
        t_req r;
        int   y, m;
        r.op = 2'($urandom_range(0, 2));
        y = $urandom_range(BASE_YEAR, LAST_YEAR);
        m = $urandom_range(1, 12);
        r.ya = 12'(y); r.ma = 4'(m); r.da = 5'($urandom_range(1, days_in_month(m, y)));
        y = $urandom_range(BASE_YEAR, LAST_YEAR);
        m = $urandom_range(1, 12);
        r.yb = 12'(y); r.mb = 4'(m); r.db = 5'($urandom_range(1, days_in_month(m, y)));
        r.dn = 17'($urandom_range(1, 93503));
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 5))
                0: r.op = 2'd3;
                1: r.da = 5'($urandom);
                2: r.ma = 4'($urandom);
                3: r.ya = 12'($urandom);
                4: begin r.db = 5'($urandom); r.mb = 4'($urandom); r.yb = 12'($urandom); end
                default: r.dn = 17'($urandom);
            endcase
        end
        return r;
    endfunction

    task automatic send(t_req r);
        while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.operation <= r.op;
        req_ch.day_a <= r.da; req_ch.month_a <= r.ma; req_ch.year_a <= r.ya;
        req_ch.day_b <= r.db; req_ch.month_b <= r.mb; req_ch.year_b <= r.yb;
        req_ch.day_number_in <= r.dn;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(negedge i_clk); while (expected_q.size() != 0);
    endtask

    // expectations are pushed at the accepting edge, so they precede their results
    always @(posedge i_clk) begin
        t_req r;
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            r = '{op: req_ch.operation, da: req_ch.day_a, ma: req_ch.month_a,
                  ya: req_ch.year_a, db: req_ch.day_b, mb: req_ch.month_b,
                  yb: req_ch.year_b, dn: req_ch.day_number_in};
            expected_q.push_back(convert(r));
            n_sent++;
        end
    end

    always @(posedge i_clk) begin
        t_res w;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            n_checked++;
            if (expected_q.size() == 0) begin
                n_errors++;
                $display("MISMATCH unexpected result %0d", n_checked);
            end else begin
                w = expected_q.pop_front();
                if (w.err) n_bad++;
                if (rsp_ch.day_out !== w.day) report_mismatch("day", rsp_ch.day_out, w.day);
                if (rsp_ch.month_out !== w.month)
                    report_mismatch("month", rsp_ch.month_out, w.month);
                if (rsp_ch.year_out !== w.year) report_mismatch("year", rsp_ch.year_out, w.year);
                if (rsp_ch.day_number_out !== w.num)
                    report_mismatch("day number", rsp_ch.day_number_out, w.num);
                if (rsp_ch.status !== w.err) report_mismatch("status", rsp_ch.status, w.err);
            end
        end
    end

    always @(negedge i_clk) begin
        rsp_ch.ready <= !hold_rsp && !(idle_pct > 0 && $urandom_range(0, 99) < idle_pct);
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d idle cycles", quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        rsp_ch.ready = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.operation = '0;
        req_ch.day_a = '0; req_ch.month_a = '0; req_ch.year_a = '0;
        req_ch.day_b = '0; req_ch.month_b = '0; req_ch.year_b = '0;
        req_ch.day_number_in = '0;
    end

    initial begin
        t_row rows[$];
        t_req r;
        t_res ok_num, err_res;
        ok_num = '{default: '0};
        err_res = '{default: '0};
        err_res.err = 1'b1;

        r = blank_req(OP_TO_NUM); ok_num.num = 17'd1;
        rows.push_back('{r, 1'b1, ok_num});
        r = blank_req(OP_TO_NUM); r.da = 5'd31; r.ma = 4'd12; r.ya = 12'd2156;
        ok_num.num = 17'd93503;
        rows.push_back('{r, 1'b1, ok_num});
        r = blank_req(OP_TO_NUM); r.ya = 12'd1900; rows.push_back('{r, 1'b1, err_res});
        r = blank_req(OP_TO_NUM); r.ya = 12'd2157; rows.push_back('{r, 1'b1, err_res});
        r = blank_req(OP_TO_NUM); r.ma = 4'd0; rows.push_back('{r, 1'b1, err_res});
        r = blank_req(OP_TO_NUM); r.ma = 4'd13; rows.push_back('{r, 1'b1, err_res});
        r = blank_req(OP_TO_NUM); r.da = 5'd0; rows.push_back('{r, 1'b1, err_res});
        r = blank_req(OP_TO_NUM); r.da = 5'd31; r.ma = 4'd4; rows.push_back('{r, 1'b1, err_res});
        r = blank_req(OP_TO_NUM); r.da = 5'd29; r.ma = 4'd2; r.ya = 12'd2100;
        rows.push_back('{r, 1'b1, err_res});
        r = blank_req(OP_TO_NUM); r.da = 5'd29; r.ma = 4'd2; r.ya = 12'd2000;
        rows.push_back('{r, 1'b0, ok_num});
        r = blank_req(OP_TO_NUM); r.da = 5'd29; r.ma = 4'd2; r.ya = 12'd1904;
        rows.push_back('{r, 1'b0, ok_num});
        r = blank_req(OP_TO_NUM); r.da = 5'd31; r.ma = 4'd15; r.ya = 12'hFFF;
        rows.push_back('{r, 1'b1, err_res});
        r = blank_req(OP_TO_DATE); r.dn = 17'd0; rows.push_back('{r, 1'b1, err_res});
        r = blank_req(OP_TO_DATE); r.dn = 17'd93504; rows.push_back('{r, 1'b1, err_res});
        r = blank_req(OP_TO_DATE); r.dn = 17'h1FFFF; rows.push_back('{r, 1'b1, err_res});
        r = blank_req(OP_TO_DATE); r.dn = 17'd1; rows.push_back('{r, 1'b0, ok_num});
        r = blank_req(OP_TO_DATE); r.dn = 17'd93503; rows.push_back('{r, 1'b0, ok_num});
        r = blank_req(OP_TO_DATE); r.dn = 17'd36584; rows.push_back('{r, 1'b0, ok_num});
        r = blank_req(OP_TO_DATE); r.dn = 17'd36525; rows.push_back('{r, 1'b0, ok_num});
        r = blank_req(OP_DIFF); ok_num.num = 17'd0; rows.push_back('{r, 1'b1, ok_num});
        r = blank_req(OP_DIFF); r.db = 5'd31; r.mb = 4'd12; r.yb = 12'd2156;
        ok_num.num = 17'd93502;
        rows.push_back('{r, 1'b1, ok_num});
        r = blank_req(OP_DIFF); r.da = 5'd31; r.ma = 4'd12; r.ya = 12'd2156;
        rows.push_back('{r, 1'b1, ok_num});
        r = blank_req(OP_DIFF); r.mb = 4'd13; rows.push_back('{r, 1'b1, err_res});
        r = blank_req(OP_DIFF); r.ya = 12'd0; rows.push_back('{r, 1'b1, err_res});
        r = blank_req(OP_BAD); rows.push_back('{r, 1'b1, err_res});

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            if (rows[i].fixed && convert(rows[i].req) != rows[i].res) begin
                n_errors++;
                $display("MISMATCH table row %0d disagrees with prediction", i);
            end
            send(rows[i].req);
        end
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 200) begin
                hold_rsp = 1'b1;
                fork
                    begin
                        repeat (300) @(negedge i_clk);
                        hold_rsp = 1'b0;
                    end
                join_none
            end
            if (i == 400) idle_pct = 0;
            if (i == 600) idle_pct = 12;
            if (i == 800) wait_drained();
            send(random_date_req());
        end
        wait_drained();
        repeat (20) @(negedge i_clk);

        $display("Sent %0d requests, checked %0d results, %0d with error status",
                 n_sent, n_checked, n_bad);
        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches, %0d results missing", n_errors, expected_q.size());
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

/* calendar_day_number_converter.f */
rtl/core/cdn_pkg.sv
rtl/core/cdn_in_if.sv
rtl/core/cdn_out_if.sv
rtl/core/cdn_date_to_num.sv
rtl/core/cdn_num_to_date.sv
rtl/core/calendar_day_number_converter.sv
rtl/core/cdn_checker.sv
bench/calendar_day_number_converter_test.sv
